// ----- rtl/core/ps2mt_pkg.sv -----
package ps2mt_pkg;

  // Fixed widths of the stream fields
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COORD_W = 12;
  localparam int unsigned BTN_W   = 3;
  localparam int unsigned SENS_W  = 12;
  localparam int unsigned SCR_W   = 13;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLED       = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 4'd3;

  // Packet format
  localparam int unsigned PACKET_BYTES = 3;
  localparam int unsigned SYNC_BIT_POS = 3;

  // Sensitivity limits in 1/256 units
  localparam logic [SENS_W-1:0] SENS_MIN   = 12'd32;
  localparam logic [SENS_W-1:0] SENS_MAX   = 12'd2048;
  localparam logic [SENS_W-1:0] SENS_RESET = 12'd256;

  // Screen limits and reset values (stored as the largest coordinate)
  localparam logic [SCR_W-1:0]   SCREEN_MAX  = 13'd4096;
  localparam logic [COORD_W-1:0] X_TOP_RESET = 12'd319;
  localparam logic [COORD_W-1:0] Y_TOP_RESET = 12'd199;
  localparam logic [COORD_W-1:0] POS_X_RESET = 12'd160;
  localparam logic [COORD_W-1:0] POS_Y_RESET = 12'd100;

  // Scaled delta: |byte * 2048 / 256| <= 1024
  localparam int unsigned DELTA_W = 12;

  // Position inside a packet
  typedef enum logic [PACKET_BYTES-1:0] {
    POS_STATUS = 3'b001,
    POS_DX     = 3'b010,
    POS_DY     = 3'b100
  } pos_t;

  // Effective configuration, already limited to its legal range
  typedef struct packed {
    logic               enabled;
    logic [SENS_W-1:0]  sens;
    logic [COORD_W-1:0] x_top;
    logic [COORD_W-1:0] y_top;
  } cfg_t;

  // One result beat
  typedef struct packed {
    logic [COORD_W-1:0] pointer_x;
    logic [COORD_W-1:0] pointer_y;
    logic [BTN_W-1:0]   button_bits;
    logic               packet_done;
    logic               byte_dropped;
  } res_t;

endpackage

// ----- rtl/core/ps2mt_cfg.sv -----
module ps2mt_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ps2mt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ps2mt_pkg::CFG_DATA_W-1:0]    cfg_data,
  output ps2mt_pkg::cfg_t                     cfg
);
  import ps2mt_pkg::*;

  logic               enabled_r;
  logic [SENS_W-1:0]  sens_r;
  logic [COORD_W-1:0] x_top_r;
  logic [COORD_W-1:0] y_top_r;

  logic [SENS_W-1:0]  sens_in;
  logic [SENS_W-1:0]  sens_lim;
  logic [SCR_W-1:0]   scr_in;
  logic [SCR_W-1:0]   scr_lim;
  logic [COORD_W-1:0] top_lim;

  assign cfg_ready = 1'b1;

  // Limit sensitivity to its legal range
  assign sens_in = cfg_data[SENS_W-1:0];
  always_comb begin
    if (sens_in < SENS_MIN) begin
      sens_lim = SENS_MIN;
    end else if (sens_in > SENS_MAX) begin
      sens_lim = SENS_MAX;
    end else begin
      sens_lim = sens_in;
    end
  end

  // Limit screen size and convert to the largest coordinate
  assign scr_in = cfg_data[SCR_W-1:0];
  always_comb begin
    if (scr_in == '0) begin
      scr_lim = SCR_W'(1);
    end else if (scr_in > SCREEN_MAX) begin
      scr_lim = SCREEN_MAX;
    end else begin
      scr_lim = scr_in;
    end
  end
  assign top_lim = COORD_W'(scr_lim - SCR_W'(1));

  // Register writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
      sens_r    <= SENS_RESET;
      x_top_r   <= X_TOP_RESET;
      y_top_r   <= Y_TOP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENABLED:       enabled_r <= cfg_data[0];
        REG_SENSITIVITY:   sens_r    <= sens_lim;
        REG_SCREEN_WIDTH:  x_top_r   <= top_lim;
        REG_SCREEN_HEIGHT: y_top_r   <= top_lim;
        default: ;
      endcase
    end
  end

  assign cfg.enabled = enabled_r;
  assign cfg.sens    = sens_r;
  assign cfg.x_top   = x_top_r;
  assign cfg.y_top   = y_top_r;

endmodule

// ----- rtl/core/ps2mt_scale.sv -----
module ps2mt_scale (
  input  logic [ps2mt_pkg::BYTE_W-1:0]         delta_byte,
  input  logic [ps2mt_pkg::SENS_W-1:0]         sens,
  output logic signed [ps2mt_pkg::DELTA_W-1:0] delta_scaled
);
  import ps2mt_pkg::*;

  localparam int unsigned PROD_W = BYTE_W + SENS_W + 1;

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_adj;
  logic signed [PROD_W-1:0] quot;

  // Signed byte times unsigned sensitivity
  assign prod = PROD_W'($signed(delta_byte)) * $signed({1'b0, sens});

  // Divide by 256, truncating toward zero
  assign prod_adj = prod[PROD_W-1] ? (prod + PROD_W'(255)) : prod;
  assign quot     = prod_adj >>> 8;

  assign delta_scaled = quot[DELTA_W-1:0];

endmodule

// ----- rtl/core/ps2mt_track.sv -----
module ps2mt_track (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ps2mt_pkg::cfg_t               cfg,
  input  logic                          fire,
  input  logic [ps2mt_pkg::BYTE_W-1:0]  rx_byte,
  output ps2mt_pkg::res_t               res
);
  import ps2mt_pkg::*;

  localparam int unsigned SUM_W = COORD_W + 2;

  pos_t                       pos_r, pos_nxt;
  logic [BTN_W-1:0]           status_r, status_nxt;
  logic [BYTE_W-1:0]          dx_r, dx_nxt;
  logic [COORD_W-1:0]         pos_x_r, pos_x_nxt;
  logic [COORD_W-1:0]         pos_y_r, pos_y_nxt;
  logic [BTN_W-1:0]           btn_r, btn_nxt;
  logic                       done;
  logic                       dropped;

  logic signed [DELTA_W-1:0]  dx_scaled;
  logic signed [DELTA_W-1:0]  dy_scaled;
  logic signed [SUM_W-1:0]    sum_x;
  logic signed [SUM_W-1:0]    sum_y;
  logic [COORD_W-1:0]         clamp_x;
  logic [COORD_W-1:0]         clamp_y;

  // Scale both deltas on the third byte with the sensitivity in force then
  ps2mt_scale u_scale_x (
    .delta_byte   (dx_r),
    .sens         (cfg.sens),
    .delta_scaled (dx_scaled)
  );

  ps2mt_scale u_scale_y (
    .delta_byte   (rx_byte),
    .sens         (cfg.sens),
    .delta_scaled (dy_scaled)
  );

  // Move and clamp both coordinates
  assign sum_x = $signed({2'b00, pos_x_r}) + SUM_W'(dx_scaled);
  assign sum_y = $signed({2'b00, pos_y_r}) - SUM_W'(dy_scaled);

  always_comb begin
    if (sum_x[SUM_W-1]) begin
      clamp_x = '0;
    end else if (sum_x[SUM_W-2:0] > {1'b0, cfg.x_top}) begin
      clamp_x = cfg.x_top;
    end else begin
      clamp_x = sum_x[COORD_W-1:0];
    end
    if (sum_y[SUM_W-1]) begin
      clamp_y = '0;
    end else if (sum_y[SUM_W-2:0] > {1'b0, cfg.y_top}) begin
      clamp_y = cfg.y_top;
    end else begin
      clamp_y = sum_y[COORD_W-1:0];
    end
  end

  // Packet assembly
  always_comb begin
    pos_nxt    = pos_r;
    status_nxt = status_r;
    dx_nxt     = dx_r;
    pos_x_nxt  = pos_x_r;
    pos_y_nxt  = pos_y_r;
    btn_nxt    = btn_r;
    done       = 1'b0;
    dropped    = 1'b0;
    if (!cfg.enabled) begin
      dropped = 1'b1;
    end else begin
      case (pos_r)
        POS_STATUS: begin
          if (!rx_byte[SYNC_BIT_POS]) begin
            dropped = 1'b1;
          end else begin
            status_nxt = rx_byte[BTN_W-1:0];
            pos_nxt    = POS_DX;
          end
        end
        POS_DX: begin
          dx_nxt  = rx_byte;
          pos_nxt = POS_DY;
        end
        POS_DY: begin
          pos_x_nxt = clamp_x;
          pos_y_nxt = clamp_y;
          btn_nxt   = status_r;
          pos_nxt   = POS_STATUS;
          done      = 1'b1;
        end
        default: begin
          pos_nxt = POS_STATUS;
        end
      endcase
    end
  end

  // Commit state when the beat is processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= POS_STATUS;
      status_r <= '0;
      dx_r     <= '0;
      pos_x_r  <= POS_X_RESET;
      pos_y_r  <= POS_Y_RESET;
      btn_r    <= '0;
    end else if (fire) begin
      pos_r    <= pos_nxt;
      status_r <= status_nxt;
      dx_r     <= dx_nxt;
      pos_x_r  <= pos_x_nxt;
      pos_y_r  <= pos_y_nxt;
      btn_r    <= btn_nxt;
    end
  end

  assign res.pointer_x    = pos_x_nxt;
  assign res.pointer_y    = pos_y_nxt;
  assign res.button_bits  = btn_nxt;
  assign res.packet_done  = done;
  assign res.byte_dropped = dropped;

  // A disabled device leaves the pointer and packet position untouched
  a_disabled_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !cfg.enabled) |=> ($stable(pos_x_r) && $stable(pos_y_r) && $stable(pos_r)))
    else $error("pointer state moved while disabled");

  // A completed packet restarts at the status byte
  a_done_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.packet_done) |=> (pos_r == POS_STATUS))
    else $error("packet position not restarted after completion");

  // A first byte without sync is dropped
  a_sync_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (pos_r == POS_STATUS) && !rx_byte[SYNC_BIT_POS]) |-> res.byte_dropped)
    else $error("unsynced first byte not dropped");

endmodule

// ----- rtl/core/ps2_mouse_pointer_tracker.sv -----
// Channel | Direction | Beat content
// in_     | in        | tdata[7:0] rx_byte
// out_    | out       | tdata pointer_x, pointer_y, button_bits; tuser packet_done,
//         |           | byte_dropped
// cfg_    | in        | cfg_index register, cfg_data value
//
// One byte per cycle while out_ is not stalled: a byte waits in the input
// register, where the scaler and clamp update the pointer, and then moves on
// to the result register that drives out_. Reset (rst_n low, synchronous)
// restores the register defaults and the pointer at (160, 100). A stalled
// out_ port holds its beat; in_ keeps accepting as long as the input register
// can drain.
module ps2_mouse_pointer_tracker (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [7:0]                             in_tdata,   // [7:0] rx_byte
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // [11:0] pointer_x, [23:12] pointer_y, [26:24] button_bits, [31:27] zero
  output logic [31:0]                            out_tdata,
  output logic [1:0]                             out_tuser,  // [0] packet_done, [1] byte_dropped
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [ps2mt_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ps2mt_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import ps2mt_pkg::*;

  localparam int unsigned DATA_BITS = 2 * COORD_W + BTN_W;

  cfg_t              cfg;
  res_t              res;
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              adv;
  logic              fire;
  logic              out_valid_r;
  res_t              out_res_r;

  ps2mt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Stage handshake: the result register frees up or is empty
  assign adv       = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && adv;
  assign in_tready = !s1_valid_r || adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata[BYTE_W-1:0];
    end
  end

  ps2mt_track u_track (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .fire    (fire),
    .rx_byte (s1_byte_r),
    .res     (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(32 - DATA_BITS)'(0), out_res_r.button_bits,
                       out_res_r.pointer_y, out_res_r.pointer_x};
  assign out_tuser  = {out_res_r.byte_dropped, out_res_r.packet_done};

endmodule

// ----- bench/ps2_pointer_checker.sv -----
`timescale 1ns / 1ps

module ps2_pointer_checker
  import ps2mt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [7:0]            in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [31:0]           out_tdata,
  input  logic [1:0]            out_tuser,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int unsigned           error_count,
  output int unsigned           pending_count
);

  localparam int unsigned PRINT_CAP = 40;
  localparam int          SENS_UNIT = 256;

  // Bit positions of the result fields inside out_tdata
  localparam int unsigned Y_LSB   = COORD_W;
  localparam int unsigned BTN_LSB = 2 * COORD_W;
  localparam int unsigned PAD_LSB = 2 * COORD_W + BTN_W;

  // Register copies, kept as written
  logic              enabled_q;
  logic [SENS_W-1:0] sens_q;
  logic [SCR_W-1:0]  width_q;
  logic [SCR_W-1:0]  height_q;

  // Packet assembly and pointer state
  pos_t               slot_q;
  logic [BYTE_W-1:0]  status_q;
  logic [BYTE_W-1:0]  dx_q;
  logic [COORD_W-1:0] x_q;
  logic [COORD_W-1:0] y_q;
  logic [BTN_W-1:0]   buttons_q;

  res_t        pointer_reports[$];
  int unsigned mismatches = 0;

  // Scale a signed motion byte by the limited sensitivity, truncating toward zero
  function automatic int scaled_motion(input logic [BYTE_W-1:0] raw,
                                       input logic [SENS_W-1:0] sens);
    int gain;
    gain = int'(sens);
    if (gain < int'(SENS_MIN)) gain = int'(SENS_MIN);
    if (gain > int'(SENS_MAX)) gain = int'(SENS_MAX);
    return int'($signed(raw)) * gain / SENS_UNIT;
  endfunction

  // Clamp a coordinate to [0, size - 1], with size limited to [1, 4096]
  function automatic logic [COORD_W-1:0] clamp_to_screen(input int pos,
                                                         input logic [SCR_W-1:0] size);
    int top;
    top = int'(size);
    if (top < 1) top = 1;
    if (top > int'(SCREEN_MAX)) top = int'(SCREEN_MAX);
    top = top - 1;
    if (pos < 0) return '0;
    if (pos > top) return COORD_W'(top);
    return COORD_W'(pos);
  endfunction

  // Advance the tracker by one received byte and queue the pointer report
  task automatic track_byte(input logic [BYTE_W-1:0] rx);
    res_t r;
    r = '0;
    if (!enabled_q) begin
      r.byte_dropped = 1'b1;
    end else if (slot_q == POS_STATUS) begin
      if (!rx[SYNC_BIT_POS]) begin
        r.byte_dropped = 1'b1;
      end else begin
        status_q = rx;
        slot_q   = POS_DX;
      end
    end else if (slot_q == POS_DX) begin
      dx_q   = rx;
      slot_q = POS_DY;
    end else begin
      // Screen y grows downward, so dy moves the pointer up
      x_q       = clamp_to_screen(int'(x_q) + scaled_motion(dx_q, sens_q), width_q);
      y_q       = clamp_to_screen(int'(y_q) - scaled_motion(rx, sens_q), height_q);
      buttons_q = status_q[BTN_W-1:0];
      slot_q    = POS_STATUS;
      r.packet_done = 1'b1;
    end
    r.pointer_x   = x_q;
    r.pointer_y   = y_q;
    r.button_bits = buttons_q;
    pointer_reports.push_back(r);
  endtask

  task automatic report(input string field, input int unsigned got, input int unsigned want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("%0t: %s mismatch: got %0d, want %0d", $time, field, got, want);
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    if (!rst_n) begin
      enabled_q  = 1'b0;
      sens_q     = SENS_RESET;
      width_q    = SCR_W'(X_TOP_RESET) + 1'b1;
      height_q   = SCR_W'(Y_TOP_RESET) + 1'b1;
      slot_q     = POS_STATUS;
      status_q   = '0;
      dx_q       = '0;
      x_q        = POS_X_RESET;
      y_q        = POS_Y_RESET;
      buttons_q  = '0;
      pointer_reports.delete();
    end else begin
      // Compare each result beat with the oldest pending report
      if (out_tvalid && out_tready) begin
        if (pointer_reports.size() == 0) begin
          report("result beat with nothing pending", 1, 0);
        end else begin
          want = pointer_reports.pop_front();
          if (out_tdata[Y_LSB-1:0] !== want.pointer_x)
            report("pointer_x", out_tdata[Y_LSB-1:0], want.pointer_x);
          if (out_tdata[BTN_LSB-1:Y_LSB] !== want.pointer_y)
            report("pointer_y", out_tdata[BTN_LSB-1:Y_LSB], want.pointer_y);
          if (out_tdata[PAD_LSB-1:BTN_LSB] !== want.button_bits)
            report("button_bits", out_tdata[PAD_LSB-1:BTN_LSB], want.button_bits);
          if (out_tdata[31:PAD_LSB] !== '0)
            report("tdata padding", out_tdata[31:PAD_LSB], 0);
          if (out_tuser[0] !== want.packet_done)
            report("packet_done", out_tuser[0], want.packet_done);
          if (out_tuser[1] !== want.byte_dropped)
            report("byte_dropped", out_tuser[1], want.byte_dropped);
        end
      end

      // Track register writes; unknown indexes change nothing
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ENABLED:       enabled_q = cfg_data[0];
          REG_SENSITIVITY:   sens_q    = cfg_data[SENS_W-1:0];
          REG_SCREEN_WIDTH:  width_q   = cfg_data[SCR_W-1:0];
          REG_SCREEN_HEIGHT: height_q  = cfg_data[SCR_W-1:0];
          default: ;
        endcase
      end

      if (in_tvalid && in_tready) track_byte(in_tdata);
    end
    error_count   <= mismatches;
    pending_count <= pointer_reports.size();
  end

endmodule

// ----- bench/ps2_mouse_pointer_tracker_tb.sv -----
`timescale 1ns / 1ps

module ps2_mouse_pointer_tracker_tb;
  import ps2mt_pkg::*;

  localparam int unsigned IDLE_LIMIT    = 2000;
  localparam int unsigned MAX_WAIT      = 13;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned MODE_RUN      = 32;
  localparam int unsigned REG_COUNT     = 4;
  localparam int unsigned IDX_TOP       = (1 << CFG_IDX_W) - 1;
  localparam logic [BYTE_W-1:0] SYNC_MASK = BYTE_W'(1 << SYNC_BIT_POS);

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [31:0]           out_tdata;
  logic [1:0]            out_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int unsigned error_count;
  int unsigned pending_count;
  int unsigned quiet_cycles = 0;
  int unsigned tx_beats = 0;
  int unsigned rx_beats = 0;
  logic        tx_steady = 1'b0;
  logic        rx_steady = 1'b0;

  ps2_mouse_pointer_tracker u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  ps2_pointer_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // End the run when no beat moves on any channel for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
      $display("ps2_mouse_pointer_tracker_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int unsigned draw_wait(input logic steady);
    return steady ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // Result side: stall at random before each beat, except in steady runs
  initial begin
    int unsigned stall;
    logic        took;
    out_tready = 1'b0;
    forever begin
      if (rx_beats % MODE_RUN == 0) rx_steady = ($urandom_range(0, 3) == 0);
      rx_beats++;
      stall = draw_wait(rx_steady);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      // Sample the handshake mid-cycle, where it holds until the next edge
      do begin
        @(negedge clk);
        took = out_tvalid && out_tready;
        @(posedge clk);
      end while (!took);
    end
  end

  // Send one byte after a random gap; valid stays high for a following byte
  task automatic send_byte(input logic [BYTE_W-1:0] rx);
    int unsigned gap;
    logic        ready_now;
    if (tx_beats % MODE_RUN == 0) tx_steady = ($urandom_range(0, 3) == 0);
    tx_beats++;
    gap = draw_wait(tx_steady);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= rx;
    // Sample ready mid-cycle, where it holds until the accepting edge
    do begin
      @(negedge clk);
      ready_now = in_tready;
      @(posedge clk);
    end while (!ready_now);
  endtask

  task automatic send_packet(input logic [BYTE_W-1:0] status, input logic [BYTE_W-1:0] dx,
                             input logic [BYTE_W-1:0] dy);
    send_byte(status);
    send_byte(dx);
    send_byte(dy);
  endtask

  // Drop valid and wait until every pending report has come back
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write all registers, then a stray index that must change nothing
  task automatic program_regs(input logic en, input logic [CFG_DATA_W-1:0] sens,
                              input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    logic [CFG_DATA_W-1:0] en_word;
    en_word    = CFG_DATA_W'($urandom);
    en_word[0] = en;
    write_reg(REG_ENABLED, en_word);
    write_reg(REG_SENSITIVITY, sens);
    write_reg(REG_SCREEN_WIDTH, w);
    write_reg(REG_SCREEN_HEIGHT, h);
    write_reg(CFG_IDX_W'($urandom_range(REG_COUNT, IDX_TOP)), CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Mostly whole packets; the rest is noise and lone status bytes that shift framing
  task automatic run_traffic(input int unsigned count);
    int unsigned sent;
    int unsigned pick;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        send_byte(BYTE_W'($urandom));
        sent++;
      end else if (pick == 1) begin
        send_byte(BYTE_W'($urandom) | SYNC_MASK);
        sent++;
      end else begin
        send_packet(BYTE_W'($urandom) | SYNC_MASK, BYTE_W'($urandom), BYTE_W'($urandom));
        sent += 3;
      end
    end
  endtask

  task automatic run_phase(input logic en, input logic [CFG_DATA_W-1:0] sens,
                           input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                           input int unsigned count);
    program_regs(en, sens, w, h);
    run_traffic(count);
    settle();
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_size();
    return ($urandom_range(0, 1) != 0) ? CFG_DATA_W'($urandom_range(1, 700))
                                       : CFG_DATA_W'($urandom_range(0, 8191));
  endfunction

  initial begin
    int unsigned p;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Disabled after reset: every byte is dropped
    send_byte(8'h08);
    send_byte(8'hFF);
    send_byte(8'h00);
    settle();

    // Enable with default sensitivity and screen size
    write_reg(REG_ENABLED, CFG_DATA_W'(1));
    cfg_valid <= 1'b0;
    send_byte(8'h00);                      // no sync bit
    send_byte(8'hF7);                      // all bits but sync
    send_packet(8'h0F, 8'h7F, 8'h7F);      // all buttons, largest positive motion
    send_packet(8'h08, 8'h80, 8'h80);      // largest negative motion
    send_packet(8'hFF, 8'hFF, 8'h01);      // status with every bit set
    send_packet(8'h09, 8'h00, 8'h00);      // no motion
    send_packet(8'h0A, 8'h7F, 8'h80);      // push into bottom edge
    send_packet(8'h0C, 8'h7F, 8'h00);      // push into right edge
    settle();

    // Register extremes, including values outside the legal range
    run_phase(1'b1, 13'd0, 13'd0, 13'd0, 60);
    run_phase(1'b1, 13'h1FFF, 13'h1FFF, 13'h1FFF, 120);
    run_phase(1'b1, 13'd32, 13'd1, 13'd4096, 100);
    run_phase(1'b1, 13'd2048, 13'd4096, 13'd1, 100);
    run_phase(1'b1, 13'd31, 13'd2, 13'd3, 80);
    run_phase(1'b1, 13'd2049, 13'd4097, 13'd4097, 100);
    run_phase(1'b0, CFG_DATA_W'($urandom), pick_size(), pick_size(), 30);

    // Random settings
    for (p = 0; p < 6; p++)
      run_phase(1'b1, CFG_DATA_W'($urandom_range(0, 4095)), pick_size(), pick_size(), 100);

    if (error_count == 0 && pending_count == 0) begin
      $display("ps2_mouse_pointer_tracker_tb: done, clean");
    end else begin
      $display("ps2_mouse_pointer_tracker_tb: done, errors");
    end
    $finish;
  end

endmodule
